FILE: hdl/bldr_pkg.sv
// ============================================================================
// bldr_pkg: shared types and constants of the button log delta encoder
// Payload structs, the command that passes from the front end to the back
// end, and the fixed constants of the log record format.
// ============================================================================
`default_nettype none

package bldr_pkg;

    // Default parameter values.
    localparam int BUTTON_BITS_DEF = 12;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Log record format.
    localparam logic [3:0]  FULL_TAG  = 4'hC;
    localparam int          TAG_SHIFT = 11;
    localparam int          TOUCH_BIT = 9;
    localparam int          DOWN_BIT  = 7;
    localparam logic [15:0] FULL_BASE = 16'(16'(FULL_TAG) << TAG_SHIFT);

    // Input item of one frame.
    typedef struct packed {
        logic [11:0] buttons_held;
        logic        touch;
        logic        logging_on;
        logic        position_valid;
        logic        finish_request;
    } t_in_item;

    // One halfword write or display result.
    typedef struct packed {
        logic               target;
        logic signed [15:0] write_index;
        logic [15:0]        write_data;
        logic               stop_logging;
        logic               last;
    } t_out_item;

    // How the frame was logged.
    typedef enum logic [1:0] {
        LOG_NONE,
        LOG_FULL,
        LOG_TOGGLE,
        LOG_INC
    } t_log_kind;

    // Work for the back end: everything needed to emit the results of one item.
    typedef struct packed {
        t_log_kind   kind;
        logic        finish;
        logic [15:0] rec_index;
        logic [15:0] rec_data;
        logic [15:0] hdr_data;
        logic [15:0] offset;
    } t_cmd;

    // Queue status seen by the front and back ends.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

FILE: hdl/bldr_front.sv
// ============================================================================
// bldr_front: frame classifier and log state
// Accepts frames, compares them with the last logged state, updates the log
// position state and hands one command per productive frame to the queue.
// ============================================================================
`default_nettype none

module bldr_front
    import bldr_pkg::*;
#(
    parameter int BUTTON_BITS = BUTTON_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    input  wire t_q_status   i_q_status,
    output logic             o_push,
    output t_cmd             o_cmd
);

    localparam int          LOW_W  = (BUTTON_BITS > 1) ? $clog2(BUTTON_BITS) : 1;
    localparam logic [15:0] MASK16 = 16'((32'd1 << BUTTON_BITS) - 32'd1);

    logic [15:0]            r_offset;
    logic [15:0]            r_write_pos;
    logic [15:0]            r_seg_start;
    logic [BUTTON_BITS-1:0] r_prev;
    logic [15:0]            r_last_word;

    logic [15:0]            n_write_pos;
    logic [15:0]            n_seg_start;
    logic [15:0]            n_last_word;

    logic                   accept;
    logic [15:0]            held16;
    logic [BUTTON_BITS-1:0] held;
    logic [BUTTON_BITS-1:0] diff;
    logic                   one_hot;
    logic [LOW_W-1:0]       low;
    logic                   seg_begin;
    logic                   full;
    logic                   finish_now;
    logic                   logged;
    logic [15:0]            half_size;
    logic [15:0]            rec_tog;
    logic [15:0]            logged_pos;
    t_log_kind              kind;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;

    // Button state of this frame with touch folded in.
    always_comb begin
        held16 = {4'd0, i_in_data.buttons_held};
        held16[TOUCH_BIT] = held16[TOUCH_BIT] | i_in_data.touch;
        held16 = held16 & MASK16;
    end
    assign held = held16[BUTTON_BITS-1:0];

    // Change detection against the last logged frame.
    assign diff    = r_prev ^ held;
    assign one_hot = (diff != '0) && ((diff & (diff - 1'b1)) == '0);

    always_comb begin
        low = '0;
        for (int i = 0; i < BUTTON_BITS; i++) begin
            if (diff[i]) begin
                low = low | LOW_W'(i);
            end
        end
    end

    assign seg_begin = ({1'b0, r_write_pos} == ({1'b0, r_seg_start} + 17'd4));
    assign full      = seg_begin || ((diff != '0) && !one_hot);
    assign half_size = {1'b0, r_write_pos[15:1]};
    assign rec_tog   = 16'(16'(low) << TAG_SHIFT);

    assign finish_now = i_in_data.finish_request && held16[DOWN_BIT];
    assign logged     = i_in_data.position_valid;

    always_comb begin
        if (!logged) begin
            kind = LOG_NONE;
        end else if (full) begin
            kind = LOG_FULL;
        end else if (diff == '0) begin
            kind = LOG_INC;
        end else begin
            kind = LOG_TOGGLE;
        end
    end

    // Next log state after this frame.
    always_comb begin
        logged_pos  = r_write_pos;
        n_last_word = r_last_word;
        o_cmd.rec_index = half_size;
        o_cmd.rec_data  = 16'd0;
        case (kind)
            LOG_FULL: begin
                logged_pos     = r_write_pos + 16'd4;
                n_last_word    = 16'd0;
                o_cmd.rec_data = FULL_BASE | held16;
            end
            LOG_TOGGLE: begin
                logged_pos     = r_write_pos + 16'd2;
                n_last_word    = rec_tog;
                o_cmd.rec_data = rec_tog;
            end
            LOG_INC: begin
                n_last_word     = r_last_word + 16'd1;
                o_cmd.rec_index = half_size - 16'd1;
                o_cmd.rec_data  = r_last_word + 16'd1;
            end
            default: begin
            end
        endcase
        n_write_pos = finish_now ? r_offset : logged_pos;
        n_seg_start = finish_now ? r_offset : r_seg_start;
        o_cmd.kind     = kind;
        o_cmd.finish   = finish_now;
        o_cmd.hdr_data = logged_pos;
        o_cmd.offset   = r_offset;
    end

    assign o_push = accept && i_in_data.logging_on && (logged || finish_now);

    // Log state and configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= 16'd0;
            r_write_pos <= 16'd4;
            r_seg_start <= 16'd0;
            r_prev      <= '0;
            r_last_word <= 16'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_offset <= i_cfg_wr_data;
            end
            if (accept && i_in_data.logging_on) begin
                r_write_pos <= n_write_pos;
                r_seg_start <= n_seg_start;
                r_last_word <= n_last_word;
                if (logged) begin
                    r_prev <= held;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bldr_queue.sv
// ============================================================================
// bldr_queue: command queue between front and back ends
// A small register FIFO so that the classifier and the result sequencer can
// stall independently.
// ============================================================================
`default_nettype none

module bldr_queue
    import bldr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_pop,
    output t_cmd       o_cmd,
    output t_q_status  o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Storage, written at the tail.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bldr_back.sv
// ============================================================================
// bldr_back: result sequencer
// Walks the head command through its record, header and finish writes and
// presents one result per cycle, while the output is not stalled, in a registered output stage.
// ============================================================================
`default_nettype none

module bldr_back
    import bldr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire t_q_status  i_q_status,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_item       o_out_data
);

    typedef enum logic [2:0] {
        PH_REC,
        PH_ZERO,
        PH_HDR,
        PH_FIN_SEG,
        PH_FIN_HDR,
        PH_FIN_SHOW
    } t_phase;

    logic      r_mid;
    t_phase    r_phase;
    logic      r_out_valid;
    t_out_item r_out_data;

    t_phase    cur_phase;
    t_phase    next_phase;
    logic      is_last;
    logic      load;
    logic      take;
    t_out_item result;

    // Phase of the head command: its first phase unless already started.
    always_comb begin
        if (r_mid) begin
            cur_phase = r_phase;
        end else if (i_cmd.kind == LOG_NONE) begin
            cur_phase = PH_FIN_SEG;
        end else begin
            cur_phase = PH_REC;
        end
    end

    // Following phase and the result of the current one.
    always_comb begin
        next_phase = PH_FIN_SEG;
        is_last    = 1'b0;
        result.target       = 1'b0;
        result.write_index  = 16'sd0;
        result.write_data   = 16'd0;
        result.stop_logging = 1'b0;
        unique case (cur_phase)
            PH_REC: begin
                result.write_index = $signed(i_cmd.rec_index);
                result.write_data  = i_cmd.rec_data;
                if (i_cmd.kind == LOG_FULL) begin
                    next_phase = PH_ZERO;
                end else if (i_cmd.kind == LOG_TOGGLE) begin
                    next_phase = PH_HDR;
                end else begin
                    is_last = !i_cmd.finish;
                end
            end
            PH_ZERO: begin
                result.write_index = $signed(i_cmd.rec_index + 16'd1);
                next_phase = PH_HDR;
            end
            PH_HDR: begin
                result.write_data = i_cmd.hdr_data;
                is_last = !i_cmd.finish;
            end
            PH_FIN_SEG: begin
                result.write_index  = -16'sd1;
                result.write_data   = i_cmd.offset;
                result.stop_logging = 1'b1;
                next_phase = PH_FIN_HDR;
            end
            PH_FIN_HDR: begin
                result.write_data   = i_cmd.offset;
                result.stop_logging = 1'b1;
                next_phase = PH_FIN_SHOW;
            end
            PH_FIN_SHOW: begin
                result.target       = 1'b1;
                result.write_data   = {1'b0, i_cmd.offset[15:1]};
                result.stop_logging = 1'b1;
                is_last = 1'b1;
            end
            default: begin
                is_last = 1'b1;
            end
        endcase
        result.last = is_last;
    end

    assign load  = !r_out_valid || !i_out_stall;
    assign take  = load && !i_q_status.empty;
    assign o_pop = take && is_last;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Sequencer state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid       <= 1'b0;
            r_phase     <= PH_REC;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= take;
            if (take) begin
                r_out_data <= result;
                r_mid      <= !is_last;
                r_phase    <= next_phase;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/button_log_delta_rle_encoder_core.sv
// ============================================================================
// button_log_delta_rle_encoder_core: button log delta run-length encoder
// Turns per-frame button states into halfword log writes: full records,
// single-bit toggle records and repeat counts, plus finish and size reports.
// ============================================================================
// The first result of a frame passes through the command queue and is valid
// once the back-end output register holds it.
// Throughput: one result per cycle from the back-end output register while the
// output is not stalled; a frame yields one to six results, and frames that
// neither log nor finish push no command and use no queue slot.
// Reset: synchronous, active low; write position 4, segment start 0, restart
// offset 0, previous state and last word 0, queue and output empty.
`default_nettype none

module button_log_delta_rle_encoder_core
    import bldr_pkg::*;
#(
    parameter int BUTTON_BITS = BUTTON_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data
);

    logic      push;
    logic      pop;
    t_cmd      cmd_in;
    t_cmd      cmd_head;
    t_q_status q_status;

    // Front end: classification and log state.
    bldr_front #(
        .BUTTON_BITS (BUTTON_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_cmd         (cmd_in)
    );

    // Command queue.
    bldr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd_in),
        .i_pop    (pop),
        .o_cmd    (cmd_head),
        .o_status (q_status)
    );

    // Back end: result sequencing.
    bldr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Finish results only address the segment start or the size header.
    a_stop_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.stop_logging) |->
        (o_out_data.write_index == 16'sd0 || o_out_data.write_index == -16'sd1))
        else $error("finish result at a record index");

    // A display result is always the closing result of a finish.
    a_show_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.target) |->
        (o_out_data.stop_logging && o_out_data.last))
        else $error("display result not the final finish result");

    // Nothing is presented in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
